// ----- src/composition_unrank_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Composition unrank decoder assertion macros
// Shared assertion forms for the decoder: a same-cycle implication and a
// next-cycle implication, both clocked and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef COMPOSITION_UNRANK_DECODER_UNIT_ASSERT_SVH
`define COMPOSITION_UNRANK_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CUD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cud: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CUD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cud: next-cycle check failed");

`endif

// ----- src/cud_pkg.sv -----
// ----------------------------------------------------------------------------
// Composition unrank decoder package
// Field widths, register indexes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package cud_pkg;

    // Field widths of the beats and of the configuration port.
    localparam int CODE_W        = 64;
    localparam int COUNT_W       = 4;
    localparam int UNITS_W       = 9;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 9;
    localparam int PART_LIMIT_W  = 4;

    // Parameter defaults.
    localparam int DEF_MAX_PARTS = 8;
    localparam int DEF_MAX_UNITS = 256;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SUM   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_LIMIT = 4'd1;

    // Reset values of the registers.
    localparam logic [CFG_DATA_W-1:0]   RST_UNIT_SUM   = 9'd256;
    localparam logic [PART_LIMIT_W-1:0] RST_PART_LIMIT = 4'd8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CODE  = 2'd2;

endpackage

// ----- src/composition_unrank_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// Composition unrank decoder
// Unranks a lexicographic code into a composition of the configured unit
// sum over the requested number of parts and streams one unit count per part.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_code, s_part_count) are taken on s_valid and s_ready.
//   Each accepted beat yields one result beat per part (m_units, m_status,
//   m_last) in part order, with m_last on the final one, or a single error
//   beat (units 0, status 1 or 2, last 1). The unit sum (index 0) and the
//   part limit (index 1) are written over the cfg_ channel, which is
//   always ready; other indexes are ignored.
// Operation:
//   The block holds one item at a time. It first builds a column of
//   composition counts on the single 64-bit add/subtract unit, then
//   scans candidates: every unit given to a part lowers the column of
//   counts for the parts after it, on that same unit.
// Reset and stalls:
//   Reset restores a unit sum of 256 and a part limit of 8 and drops any
//   item in flight. The result register and the emit states hold while
//   m_ready is low; the next item may be taken while the final beat is held.
// ----------------------------------------------------------------------------
`include "composition_unrank_decoder_unit_assert.svh"

module composition_unrank_decoder_unit #(
    parameter int MAX_PARTS = cud_pkg::DEF_MAX_PARTS,
    parameter int MAX_UNITS = cud_pkg::DEF_MAX_UNITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cud_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cud_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cud_pkg::CODE_W-1:0]      s_code,
    input  logic [cud_pkg::COUNT_W-1:0]     s_part_count,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cud_pkg::UNITS_W-1:0]     m_units,
    output logic [cud_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_last
);
    import cud_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PARTS);
    localparam int UNIT_W = $clog2(MAX_UNITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_ADD,
        ST_CHECK,
        ST_SCAN,
        ST_DESC,
        ST_EMIT_PART,
        ST_EMIT_LAST,
        ST_EMIT_ERR
    } state_t;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]    unit_sum_reg;
    logic [PART_LIMIT_W-1:0]  part_limit_reg;

    // Sequencer state and working registers.
    state_t                state_reg,    state_next;
    logic [CODE_W-1:0]     code_reg,     code_next;
    logic [CODE_W-1:0]     held_reg,     held_next;
    logic [IDX_W-1:0]      parts_m1_reg, parts_m1_next;
    logic [IDX_W-1:0]      rest_reg,     rest_next;
    logic [IDX_W-1:0]      j_reg,        j_next;
    logic [UNIT_W-1:0]     left_reg,     left_next;
    logic [UNIT_W-1:0]     u_reg,        u_next;
    logic [STATUS_W-1:0]   err_reg,      err_next;

    // Column of composition counts: entry i holds the count for i+1 parts
    // over the units currently left.
    logic [CODE_W-1:0]     tab_reg [MAX_PARTS];
    logic                  tab_fill;
    logic                  tab_we;
    logic [IDX_W-1:0]      tab_waddr;
    logic [IDX_W-1:0]      rd_idx;
    logic [CODE_W-1:0]     rd_data;

    // Result register.
    logic                  m_valid_reg,  m_valid_next;
    logic [UNITS_W-1:0]    m_units_reg,  m_units_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic                  m_last_reg,   m_last_next;

    // Shared add/subtract unit.
    logic [CODE_W-1:0]     alu_a;
    logic [CODE_W-1:0]     alu_b;
    logic                  alu_sub;
    logic [CODE_W-1:0]     alu_res;
    logic                  alu_carry;
    logic                  alu_borrow;

    logic                  out_free;
    logic                  bad_count;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_units   = m_units_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign rd_data   = tab_reg[rd_idx];

    // The one arithmetic unit: a + b, or a - b with a borrow flag.
    assign {alu_carry, alu_res} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                                  + (CODE_W + 1)'(alu_sub);
    assign alu_borrow = alu_sub && !alu_carry;

    // Part count or configuration that cannot be decoded.
    assign bad_count = (s_part_count == '0) ||
                       (s_part_count > part_limit_reg) ||
                       (part_limit_reg > PART_LIMIT_W'(MAX_PARTS)) ||
                       (unit_sum_reg == '0) ||
                       (unit_sum_reg > CFG_DATA_W'(MAX_UNITS));

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_sum_reg   <= RST_UNIT_SUM;
            part_limit_reg <= RST_PART_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_UNIT_SUM:   unit_sum_reg   <= cfg_data;
                CFG_PART_LIMIT: part_limit_reg <= cfg_data[PART_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        held_next     = held_reg;
        parts_m1_next = parts_m1_reg;
        rest_next     = rest_reg;
        j_next        = j_reg;
        left_next     = left_reg;
        u_next        = u_reg;
        err_next      = err_reg;
        tab_fill      = 1'b0;
        tab_we        = 1'b0;
        tab_waddr     = j_reg;
        rd_idx        = '0;
        alu_a         = code_reg;
        alu_b         = rd_data;
        alu_sub       = 1'b1;
        m_valid_next  = m_valid_reg && !m_ready;
        m_units_next  = m_units_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            // Take a beat, check it and seed the count column with ones.
            ST_IDLE: begin
                if (s_valid) begin
                    code_next     = s_code;
                    parts_m1_next = IDX_W'(s_part_count - COUNT_W'(1));
                    j_next        = IDX_W'(1);
                    held_next     = CODE_W'(1);
                    tab_fill      = 1'b1;
                    if (bad_count) begin
                        err_next   = STATUS_BAD_COUNT;
                        state_next = ST_EMIT_ERR;
                    end else if (s_part_count == COUNT_W'(1)) begin
                        left_next  = UNIT_W'(unit_sum_reg);
                        state_next = ST_CHECK;
                    end else begin
                        left_next  = '0;
                        state_next = ST_INIT_ADD;
                    end
                end
            end

            // Raise the column by one unit per pass: entry j += entry j-1.
            ST_INIT_ADD: begin
                rd_idx    = j_reg;
                alu_a     = rd_data;
                alu_b     = held_reg;
                alu_sub   = 1'b0;
                tab_we    = 1'b1;
                held_next = alu_res;
                if (j_reg == parts_m1_reg) begin
                    j_next    = IDX_W'(1);
                    held_next = CODE_W'(1);
                    left_next = left_reg + UNIT_W'(1);
                    if (UNIT_W'(left_reg + UNIT_W'(1)) == UNIT_W'(unit_sum_reg)) begin
                        state_next = ST_CHECK;
                    end
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            // The code must lie below the number of compositions.
            ST_CHECK: begin
                rd_idx = parts_m1_reg;
                if (!alu_borrow) begin
                    err_next   = STATUS_BAD_CODE;
                    state_next = ST_EMIT_ERR;
                end else begin
                    rest_next = parts_m1_reg;
                    u_next    = '0;
                    if (parts_m1_reg == '0) begin
                        state_next = ST_EMIT_LAST;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // Try one more unit for this part: skip its block of codes.
            ST_SCAN: begin
                rd_idx = rest_reg - IDX_W'(1);
                if ((left_reg == '0) || alu_borrow) begin
                    state_next = ST_EMIT_PART;
                end else begin
                    code_next = alu_res;
                    u_next    = u_reg + UNIT_W'(1);
                    left_next = left_reg - UNIT_W'(1);
                    held_next = rd_data;
                    j_next    = rest_reg - IDX_W'(1);
                    if (rest_reg != IDX_W'(1)) begin
                        state_next = ST_DESC;
                    end
                end
            end

            // Lower the column by one unit, top entry first:
            // entry j -= old entry j-1.
            ST_DESC: begin
                rd_idx    = j_reg - IDX_W'(1);
                alu_a     = held_reg;
                tab_we    = 1'b1;
                held_next = rd_data;
                if (j_reg == IDX_W'(1)) begin
                    state_next = ST_SCAN;
                end else begin
                    j_next = j_reg - IDX_W'(1);
                end
            end

            // Hand out the units of one part and move to the next part.
            ST_EMIT_PART: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_units_next  = UNITS_W'(u_reg);
                    m_status_next = STATUS_OK;
                    m_last_next   = 1'b0;
                    rest_next     = rest_reg - IDX_W'(1);
                    u_next        = '0;
                    if (rest_reg == IDX_W'(1)) begin
                        state_next = ST_EMIT_LAST;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // The last part takes every unit that is left.
            ST_EMIT_LAST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_units_next  = UNITS_W'(left_reg);
                    m_status_next = STATUS_OK;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // A single error beat ends the item.
            ST_EMIT_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_units_next  = '0;
                    m_status_next = err_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, working registers, count column and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        code_reg     <= code_next;
        held_reg     <= held_next;
        parts_m1_reg <= parts_m1_next;
        rest_reg     <= rest_next;
        j_reg        <= j_next;
        left_reg     <= left_next;
        u_reg        <= u_next;
        err_reg      <= err_next;
        m_units_reg  <= m_units_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        if (tab_fill) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
                tab_reg[i] <= CODE_W'(1);
            end
        end else if (tab_we) begin
            tab_reg[tab_waddr] <= alu_res;
        end
    end

    // An accepted beat keeps the input side closed in the following cycle.
    `CUD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Every error beat closes its item.
    `CUD_ASSERT_SAME(a_error_is_last, aclk, aresetn, m_valid && (m_status != STATUS_OK), m_last)

    // The candidate scan only runs for a part that has parts after it.
    `CUD_ASSERT_SAME(a_scan_has_rest, aclk, aresetn, state_reg == ST_SCAN, rest_reg != '0)

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Composition unrank decoder testbench
// Feeds rank codes and part counts into the decoder under several register
// settings. The bench works out each composition on its own and checks
// every result beat, field by field, against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cud_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_MAX     = 18;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX    = 4'hF;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
    } rank_item_t;

    typedef struct packed {
        logic [UNITS_W-1:0]  units;
        logic [STATUS_W-1:0] status;
        logic                last;
    } part_beat_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index      = CFG_UNIT_SUM;
    logic [CFG_DATA_W-1:0]    cfg_data       = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [CODE_W-1:0]        s_code         = '0;
    logic [COUNT_W-1:0]       s_part_count   = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [UNITS_W-1:0]       m_units;
    logic [STATUS_W-1:0]      m_status;
    logic                     m_last;

    // Register copies kept by the bench.
    logic [CFG_DATA_W-1:0]    total_mirror = RST_UNIT_SUM;
    logic [PART_LIMIT_W-1:0]  max_mirror   = RST_PART_LIMIT;

    rank_item_t codes_to_send[$];
    part_beat_t parts_due[$];

    int send_idle_max = IDLE_MAX;
    int recv_idle_max = IDLE_MAX;
    int send_wait     = 0;
    int recv_wait     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int mismatches    = 0;
    int items_taken   = 0;
    int beats_seen    = 0;
    int error_beats   = 0;
    int settings_seen = 0;

    composition_unrank_decoder_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code         (s_code),
        .s_part_count   (s_part_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_units        (m_units),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    always #4 aclk = ~aclk;

    // Binomial coefficient, exact for every size the block accepts.
    function automatic logic [63:0] n_choose_k(input int n, input int k);
        logic [63:0] r;
        r = 64'd1;
        if (k > n) begin
            return 64'd0;
        end
        if (n - k < k) begin
            k = n - k;
        end
        for (int i = 1; i <= k; i++) begin
            r = r * 64'(n - k + i) / 64'(i);
        end
        return r;
    endfunction

    // Number of ways to spread a unit count over a number of parts.
    function automatic logic [63:0] ways(input int units, input int parts);
        return n_choose_k(units + parts - 1, parts - 1);
    endfunction

    function automatic void add_part_beat(input int units, input logic [STATUS_W-1:0] status,
                                          input logic last);
        part_beat_t beat;
        beat.units  = UNITS_W'(units);
        beat.status = status;
        beat.last   = last;
        parts_due.insert(parts_due.size(), beat);
    endfunction

    // Predicts the result beats of one accepted input beat.
    function automatic void unrank_code(input logic [CODE_W-1:0] code,
                                        input logic [COUNT_W-1:0] count);
        logic [63:0] rank_left;
        logic [63:0] skip;
        int          left;
        int          u;
        int          after;
        if (count == 0 || count > max_mirror || max_mirror > DEF_MAX_PARTS ||
            total_mirror == 0 || total_mirror > DEF_MAX_UNITS) begin
            add_part_beat(0, STATUS_BAD_COUNT, 1'b1);
            return;
        end
        if (code >= ways(total_mirror, count)) begin
            add_part_beat(0, STATUS_BAD_CODE, 1'b1);
            return;
        end
        rank_left = code;
        left      = total_mirror;
        for (int p = 0; p + 1 < count; p++) begin
            after = count - p - 1;
            u     = 0;
            while (u < left) begin
                skip = ways(left - u, after);
                if (rank_left < skip) begin
                    break;
                end
                rank_left -= skip;
                u++;
            end
            add_part_beat(u, STATUS_OK, 1'b0);
            left -= u;
        end
        add_part_beat(left, STATUS_OK, 1'b1);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_rank(input logic [CODE_W-1:0] code,
                                       input logic [COUNT_W-1:0] count);
        rank_item_t item;
        item.code  = code;
        item.count = count;
        codes_to_send.insert(codes_to_send.size(), item);
    endfunction

    // Mostly well-formed codes for the current setting, some near the top
    // of the range, and the rest random part counts with raw or in-range codes.
    function automatic void queue_random(input int n);
        int                 pick;
        logic [COUNT_W-1:0] count;
        logic [63:0]        span;
        for (int i = 0; i < n; i++) begin
            pick  = $urandom_range(0, 99);
            count = COUNT_W'($urandom_range(1, max_mirror));
            span  = ways(total_mirror, count);
            if (pick < 78) begin
                queue_rank(rand_word() % span, count);
            end else if (pick < 88) begin
                queue_rank(span - 64'($urandom_range(0, 1)), count);
            end else if (pick < 94) begin
                queue_rank(rand_word(), COUNT_W'($urandom_range(0, 15)));
            end else begin
                queue_rank(rand_word() % span, COUNT_W'($urandom_range(0, 15)));
            end
        end
    endfunction

    // Input driver: one beat offered at a time, held until accepted.
    always @(posedge aclk) begin
        rank_item_t nxt;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                unrank_code(s_code, s_part_count);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    s_valid   <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (codes_to_send.size() != 0) begin
                    nxt            = codes_to_send.pop_front();
                    s_valid        <= 1'b1;
                    s_code         <= nxt.code;
                    s_part_count   <= nxt.count;
                    send_wait      <= $urandom_range(0, send_idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted beat and paces m_ready.
    always @(posedge aclk) begin
        part_beat_t want;
        int         draw;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (m_status != STATUS_OK) begin
                    error_beats++;
                end
                if (parts_due.size() == 0) begin
                    $error("unexpected beat: units %0d status %0d last %0d",
                           m_units, m_status, m_last);
                    mismatches++;
                end else begin
                    want = parts_due.pop_front();
                    if (m_units !== want.units) begin
                        $error("units: expected %0d, got %0d", want.units, m_units);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        mismatches++;
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served <= hold_requests;
                recv_wait    <= HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_ready   <= 1'b0;
            end else if (m_valid && m_ready) begin
                draw      = $urandom_range(0, recv_idle_max);
                recv_wait <= (draw == 0) ? 0 : draw - 1;
                m_ready   <= (draw == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Waits until no input is pending and every predicted beat has arrived.
    task automatic settle();
        do begin
            @(negedge aclk);
        end while (codes_to_send.size() != 0 || s_valid || parts_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_UNIT_SUM) begin
            total_mirror = data;
        end else if (idx == CFG_PART_LIMIT) begin
            max_mirror = data[PART_LIMIT_W-1:0];
        end
    endtask

    // Moves to a new register setting once the block has gone idle.
    task automatic set_regs(input logic [CFG_DATA_W-1:0] units,
                            input logic [CFG_DATA_W-1:0] actions);
        settle();
        write_reg(CFG_UNIT_SUM, units);
        write_reg(CFG_PART_LIMIT, actions);
        settings_seen++;
        @(negedge aclk);
        send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    endtask

    initial begin
        logic [63:0] span;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        settings_seen = 1;

        // Reset setting: empty and oversized part counts, first and last
        // ranks, the first rank out of range, all-ones codes and random ranks.
        span = ways(total_mirror, 8);
        queue_rank(64'd0, 4'd0);
        queue_rank(64'd0, 4'd8);
        queue_rank(span - 64'd1, 4'd8);
        queue_rank(span, 4'd8);
        queue_rank('1, 4'd8);
        queue_rank(64'd0, 4'd9);
        queue_rank('1, 4'd15);
        queue_rank(64'd0, 4'd1);
        queue_rank(64'd1, 4'd1);
        queue_rank(64'd128, 4'd2);
        queue_rank(rand_word() % span, 4'd8);
        queue_rank(rand_word() % ways(total_mirror, 5), 4'd5);

        // Smallest unit total and part limit; upper data bits are ignored
        // by the part limit register.
        set_regs(9'd1, {5'h1F, 4'd1});
        queue_rank(64'd0, 4'd1);
        queue_rank(64'd1, 4'd1);
        queue_rank(64'd0, 4'd2);
        queue_rank(64'h8000_0000_0000_0000, 4'd1);

        // Unit totals and part limits outside what the block supports.
        set_regs(9'd0, 9'd8);
        queue_rank(64'd0, 4'd1);
        queue_rank(64'd5, 4'd3);
        set_regs(9'd257, 9'd8);
        queue_rank(64'd0, 4'd1);
        set_regs(9'h1FF, 9'd8);
        queue_rank(64'd0, 4'd1);
        set_regs(9'd3, 9'd9);
        queue_rank(64'd0, 4'd2);
        set_regs(9'd3, 9'd15);
        queue_rank(64'd0, 4'd1);
        set_regs(9'd3, 9'd0);
        queue_rank(64'd0, 4'd1);

        // Writes to unused indexes must leave both registers alone.
        set_regs(9'd4, 9'd8);
        write_reg(CFG_UNUSED_IDX, 9'd0);
        write_reg(CFG_TOP_IDX, 9'h1FF);
        @(negedge aclk);
        queue_rank(64'd4, 4'd2);

        // Random codes under small unit totals, then a few at full size.
        for (int ph = 0; ph < 8; ph++) begin
            set_regs(9'($urandom_range(1, 24)), 9'($urandom_range(1, 8)));
            queue_random(11);
        end
        set_regs(9'd256, 9'd8);
        queue_random(4);
        set_regs(9'($urandom_range(100, 255)), 9'($urandom_range(5, 8)));
        queue_random(4);

        // Back-to-back input beats while the result side holds off.
        set_regs(9'd3, 9'd8);
        send_idle_max = 0;
        hold_requests++;
        queue_random(20);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d input beats and %0d result beats over %0d register settings,",
                 items_taken, beats_seen, settings_seen);
        $display("of which %0d result beats carried an error status.", error_beats);
        if (mismatches == 0 && parts_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest run this stimulus can take.
    initial begin
        #(25_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
